// ===== design/apc_pkg.sv =====
// ----------------------------------------------------------------------------
// apc_pkg
// Types, register codes, reset values and helper functions shared by the
// anaglyph pixel compositor.
// ----------------------------------------------------------------------------
package apc_pkg;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_PIXEL = 1'b1
	} action_t;

	localparam logic [2:0] REG_SWAP       = 3'd0;
	localparam logic [2:0] REG_FORMAT     = 3'd1;
	localparam logic [2:0] REG_RED_MASK   = 3'd2;
	localparam logic [2:0] REG_GREEN_MASK = 3'd3;
	localparam logic [2:0] REG_BLUE_MASK  = 3'd4;

	localparam logic [2:0] FMT_15 = 3'd0;
	localparam logic [2:0] FMT_16 = 3'd1;
	localparam logic [2:0] FMT_24 = 3'd2;
	localparam logic [2:0] FMT_30 = 3'd3;
	localparam logic [2:0] FMT_32 = 3'd4;

	localparam logic [2:0] BYTES_2 = 3'd2;
	localparam logic [2:0] BYTES_3 = 3'd3;
	localparam logic [2:0] BYTES_4 = 3'd4;

	localparam int NumChan = 3;

	localparam logic [31:0] RECIP_255   = 32'h8080_8081;
	localparam int          RecipShift  = 39;
	localparam logic [15:0] ROUND_HALF  = 16'd127;

	localparam logic [31:0] MASK_RST [NumChan] = '{32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF};
	localparam logic [4:0]  SHIFT_RST [NumChan] = '{5'd16, 5'd8, 5'd0};
	localparam logic [31:0] NORM_RST  = 32'd255;
	localparam logic [63:0] PROD_RST  = 64'd255 * 64'(RECIP_255);

	typedef struct packed {
		logic [24:0] quot;
		logic [7:0]  rem;
		logic [4:0]  shift;
	} chan_scale_t;

	typedef struct packed {
		logic        swap;
		logic [2:0]  format;
		chan_scale_t red;
		chan_scale_t green;
		chan_scale_t blue;
	} cfg_t;

	typedef struct packed {
		logic        is_write;
		logic [7:0]  addr_a;
		logic [7:0]  addr_b;
		logic [23:0] wdata;
		logic        overlay;
		logic [2:0]  bytes;
	} entry_t;

	// Exact x/255 for x below 65280.
	function automatic logic [7:0] div255_small(input logic [15:0] x);
		logic [16:0] tmp;
		tmp = 17'(x) + 17'd1 + 17'(x[15:8]);
		return tmp[15:8];
	endfunction

	// Isolates the lowest set bit and encodes its position.
	function automatic logic [4:0] trailing_zeros(input logic [31:0] m);
		logic [31:0] lsb;
		logic [4:0]  tz;
		lsb = m & (~m + 32'd1);
		tz  = '0;
		for (int i = 0; i < 32; i++) begin
			if (lsb[i]) begin
				tz = tz | 5'(i);
			end
		end
		return tz;
	endfunction

endpackage

// ===== design/apc_req_if.sv =====
// ----------------------------------------------------------------------------
// apc_req_if
// Request channel: palette writes and pixel items.
// ----------------------------------------------------------------------------
interface apc_req_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] palette_slot;
	logic [7:0] entry_red;
	logic [7:0] entry_green;
	logic [7:0] entry_blue;
	logic [7:0] left_eye_index;
	logic [7:0] right_eye_index;
	logic [7:0] current_index;

	modport source (
		output valid, action, palette_slot, entry_red, entry_green, entry_blue,
		       left_eye_index, right_eye_index, current_index,
		input  ready
	);
	modport sink (
		input  valid, action, palette_slot, entry_red, entry_green, entry_blue,
		       left_eye_index, right_eye_index, current_index,
		output ready
	);
endinterface

// ===== design/apc_res_if.sv =====
// ----------------------------------------------------------------------------
// apc_res_if
// Result channel: one packed pixel per composed item.
// ----------------------------------------------------------------------------
interface apc_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_color;
	logic [2:0]  pixel_bytes;
	logic        is_overlay;

	modport source (
		output valid, pixel_color, pixel_bytes, is_overlay,
		input  ready
	);
	modport sink (
		input  valid, pixel_color, pixel_bytes, is_overlay,
		output ready
	);
endinterface

// ===== design/apc_regs.sv =====
// ----------------------------------------------------------------------------
// apc_regs
// Configuration registers. Each channel mask is normalized into norm_q;
// its quotient and remainder by 255 are registered after product prod_q.
// ----------------------------------------------------------------------------
module apc_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [2:0]          reg_index,
	input  logic [31:0]         wr_data,
	output apc_pkg::cfg_t       cfg
);

	logic                       swap_q;
	logic [2:0]                 format_q;
	apc_pkg::chan_scale_t       scale [apc_pkg::NumChan];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q   <= 1'b0;
			format_q <= apc_pkg::FMT_32;
		end else if (wr_en) begin
			case (reg_index)
				apc_pkg::REG_SWAP:   swap_q   <= wr_data[0];
				apc_pkg::REG_FORMAT: format_q <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	for (genvar c = 0; c < apc_pkg::NumChan; c++) begin : g_chan
		localparam logic [2:0] ChanIdx = apc_pkg::REG_RED_MASK + 3'(c);

		logic [31:0] mask_q;
		logic [4:0]  shift_q;
		logic [31:0] norm_q;
		logic [63:0] prod_q;
		logic [24:0] quot_q;
		logic [7:0]  rem_q;
		logic [24:0] quot_next;
		logic [31:0] rem_next;

		assign quot_next = prod_q[apc_pkg::RecipShift +: 25];
		assign rem_next  = norm_q - ((32'(quot_next) << 8) - 32'(quot_next));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mask_q  <= apc_pkg::MASK_RST[c];
				shift_q <= apc_pkg::SHIFT_RST[c];
				norm_q  <= apc_pkg::NORM_RST;
				prod_q  <= apc_pkg::PROD_RST;
				quot_q  <= 25'd1;
				rem_q   <= 8'd0;
			end else begin
				if (wr_en && reg_index == ChanIdx) begin
					mask_q  <= wr_data;
					shift_q <= apc_pkg::trailing_zeros(wr_data);
				end
				norm_q <= mask_q >> shift_q;
				prod_q <= 64'(norm_q) * 64'(apc_pkg::RECIP_255);
				quot_q <= quot_next;
				rem_q  <= rem_next[7:0];
			end
		end

		assign scale[c] = '{quot: quot_q, rem: rem_q, shift: shift_q};
	end

	assign cfg.swap   = swap_q;
	assign cfg.format = format_q;
	assign cfg.red    = scale[0];
	assign cfg.green  = scale[1];
	assign cfg.blue   = scale[2];

endmodule

// ===== design/apc_front.sv =====
// ----------------------------------------------------------------------------
// apc_front
// Accepts request items, resolves eye selection, overlay and byte count,
// drops pixels of an unknown format and hands entries to the queue.
// ----------------------------------------------------------------------------
module apc_front (
	input  logic                clk,
	input  logic                arst_n,
	apc_req_if.sink             request,
	input  apc_pkg::cfg_t       cfg,
	input  logic                full,
	output logic                push,
	output apc_pkg::entry_t     entry
);

	logic              valid_q;
	apc_pkg::entry_t   entry_q;
	apc_pkg::entry_t   entry_d;
	logic              keep;
	logic              overlay;
	logic              accept;

	assign request.ready = !valid_q || !full;
	assign accept        = request.valid && request.ready;
	assign push          = valid_q && !full;
	assign entry         = entry_q;

	always_comb begin
		overlay          = request.current_index != request.right_eye_index;
		entry_d          = '0;
		keep             = 1'b1;
		entry_d.overlay  = overlay;
		if (request.action == apc_pkg::ACT_WRITE) begin
			entry_d.is_write = 1'b1;
			entry_d.addr_a   = request.palette_slot;
			entry_d.wdata    = {request.entry_red, request.entry_green, request.entry_blue};
		end else begin
			keep = cfg.format <= apc_pkg::FMT_32;
			if (overlay) begin
				entry_d.addr_a = request.current_index;
				entry_d.addr_b = request.current_index;
			end else if (cfg.swap) begin
				entry_d.addr_a = request.right_eye_index;
				entry_d.addr_b = request.left_eye_index;
			end else begin
				entry_d.addr_a = request.left_eye_index;
				entry_d.addr_b = request.right_eye_index;
			end
			if (cfg.format inside {apc_pkg::FMT_15, apc_pkg::FMT_16}) begin
				entry_d.bytes = apc_pkg::BYTES_2;
			end else if (cfg.format == apc_pkg::FMT_24) begin
				entry_d.bytes = apc_pkg::BYTES_3;
			end else begin
				entry_d.bytes = apc_pkg::BYTES_4;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= keep;
		end else if (push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q <= entry_d;
		end
	end

endmodule

// ===== design/apc_queue.sv =====
// ----------------------------------------------------------------------------
// apc_queue
// Small FIFO of classified entries between the front and back parts.
// ----------------------------------------------------------------------------
module apc_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  apc_pkg::entry_t     push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output apc_pkg::entry_t     head
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	apc_pkg::entry_t   slots_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_pop;

	assign full       = count_q == CntW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slots_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== design/apc_back.sv =====
// ----------------------------------------------------------------------------
// apc_back
// Owns the palette. Applies palette writes and runs pixels through a
// three-stage path: palette read, channel products, rounding and packing.
// ----------------------------------------------------------------------------
module apc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  apc_pkg::cfg_t       cfg,
	input  logic                head_valid,
	input  apc_pkg::entry_t     head,
	output logic                pop,
	apc_res_if.source           result
);

	logic [23:0]           palette_mem [256];

	logic                  advance;
	apc_pkg::chan_scale_t  scale [apc_pkg::NumChan];

	logic                  valid_s1;
	logic [23:0]           red_entry_s1;
	logic [23:0]           cyan_entry_s1;
	logic                  overlay_s1;
	logic [2:0]            bytes_s1;
	logic [7:0]            lane_v [apc_pkg::NumChan];

	logic                  valid_s2;
	logic [31:0]           whole_s2 [apc_pkg::NumChan];
	logic [15:0]           frac_s2 [apc_pkg::NumChan];
	logic                  overlay_s2;
	logic [2:0]            bytes_s2;
	logic [31:0]           color_d;

	logic                  valid_s3;
	logic [31:0]           color_s3;
	logic                  overlay_s3;
	logic [2:0]            bytes_s3;

	assign advance  = !valid_s3 || result.ready;
	assign pop      = advance && head_valid;
	assign scale[0] = cfg.red;
	assign scale[1] = cfg.green;
	assign scale[2] = cfg.blue;
	assign lane_v[0] = red_entry_s1[23:16];
	assign lane_v[1] = cyan_entry_s1[15:8];
	assign lane_v[2] = cyan_entry_s1[7:0];

	always_ff @(posedge clk) begin
		if (pop && head.is_write) begin
			palette_mem[head.addr_a] <= head.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			red_entry_s1  <= palette_mem[head.addr_a];
			cyan_entry_s1 <= palette_mem[head.addr_b];
			overlay_s1    <= head.overlay;
			bytes_s1      <= head.bytes;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int c = 0; c < apc_pkg::NumChan; c++) begin
				whole_s2[c] <= 32'(33'(lane_v[c]) * 33'(scale[c].quot));
				frac_s2[c]  <= 16'(lane_v[c]) * 16'(scale[c].rem) + apc_pkg::ROUND_HALF;
			end
			overlay_s2 <= overlay_s1;
			bytes_s2   <= bytes_s1;
		end
	end

	always_comb begin
		color_d = '0;
		for (int c = 0; c < apc_pkg::NumChan; c++) begin
			color_d = color_d |
				((whole_s2[c] + 32'(apc_pkg::div255_small(frac_s2[c]))) << scale[c].shift);
		end
		case (bytes_s2)
			apc_pkg::BYTES_2: color_d = color_d & 32'h0000_FFFF;
			apc_pkg::BYTES_3: color_d = color_d & 32'h00FF_FFFF;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			color_s3   <= color_d;
			overlay_s3 <= overlay_s2;
			bytes_s3   <= bytes_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= head_valid && !head.is_write;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign result.valid       = valid_s3;
	assign result.pixel_color = color_s3;
	assign result.pixel_bytes = bytes_s3;
	assign result.is_overlay  = overlay_s3;

`ifndef SYNTHESIS
	a_bytes_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (bytes_s3 == apc_pkg::BYTES_2 || bytes_s3 == apc_pkg::BYTES_3 ||
			bytes_s3 == apc_pkg::BYTES_4))
		else $error("result byte count out of range");

	a_two_byte_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && bytes_s3 == apc_pkg::BYTES_2) |-> (color_s3[31:16] == 16'd0))
		else $error("two-byte pixel has upper bits set");

	a_three_byte_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && bytes_s3 == apc_pkg::BYTES_3) |-> (color_s3[31:24] == 8'd0))
		else $error("three-byte pixel has top byte set");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.is_write) |=> !valid_s1)
		else $error("palette write entered the pixel path");
`endif

endmodule

// ===== design/anaglyph_pixel_compositor.sv =====
// ----------------------------------------------------------------------------
// anaglyph_pixel_compositor
// Red/cyan anaglyph composer with a 256-entry palette. Request items either
// write a palette entry or compose one packed pixel from three indices.
//
//   Channel   Role     Payload
//   request   sink     action, palette_slot, entry rgb, eye and current index
//   result    source   pixel_color, pixel_bytes, is_overlay
//   wr_en     write    reg_index selects the register, wr_data the value
//
// One request item per cycle is sustained while results are taken; pixels
// pass front register, queue and back stages. Palette writes give no result.
// Reset empties the queue and the pipeline; palette contents start undefined.
// The palette has one write and two read ports, all usable in the same cycle.
// Mask changes pass the normalize, product and quotient registers to scaling.
// Result stalls hold the back pipeline; the entry queue absorbs them.
// ----------------------------------------------------------------------------
module anaglyph_pixel_compositor #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	apc_req_if.sink     request,
	apc_res_if.source   result,
	input  logic        wr_en,
	input  logic [2:0]  reg_index,
	input  logic [31:0] wr_data
);

	apc_pkg::cfg_t     cfg;
	apc_pkg::entry_t   push_entry;
	apc_pkg::entry_t   head;
	logic              push;
	logic              full;
	logic              pop;
	logic              head_valid;

	apc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.reg_index (reg_index),
		.wr_data   (wr_data),
		.cfg       (cfg)
	);

	apc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cfg     (cfg),
		.full    (full),
		.push    (push),
		.entry   (push_entry)
	);

	apc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	apc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.result     (result)
	);

endmodule

// ===== tb/sv/tb_anaglyph_pixel_compositor.sv =====
// ----------------------------------------------------------------------------
// tb_anaglyph_pixel_compositor
// Self-checking bench for the anaglyph pixel compositor. A behavioral copy
// of the palette and the channel scaling predicts every composed pixel, and
// each result item is compared against the oldest prediction. Directed items
// cover the extreme colors, every format, rejected formats and odd masks.
// Random traffic then runs under changing register settings, random idling
// on both channels, a long result stall and pauses that drain the block.
// ----------------------------------------------------------------------------
module tb_anaglyph_pixel_compositor;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SettleCycles = 8;
	localparam int StallLimit   = 1000;
	localparam int HoldOff      = 120;

	localparam logic [2:0] FMT_UNKNOWN_MIN = apc_pkg::FMT_32 + 3'd1;
	localparam logic [2:0] FMT_UNKNOWN_MAX = 3'd7;
	localparam logic [2:0] REG_UNUSED_MIN  = apc_pkg::REG_BLUE_MASK + 3'd1;
	localparam logic [2:0] REG_UNUSED_MAX  = 3'd7;

	localparam logic [31:0] RedMaskRst   = apc_pkg::MASK_RST[0];
	localparam logic [31:0] GreenMaskRst = apc_pkg::MASK_RST[1];
	localparam logic [31:0] BlueMaskRst  = apc_pkg::MASK_RST[2];

	typedef struct {
		apc_pkg::action_t act;
		logic [7:0]       slot;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [7:0]       left;
		logic [7:0]       right;
		logic [7:0]       cur;
	} request_t;

	typedef struct {
		logic [31:0] color;
		logic [2:0]  nbytes;
		logic        overlay;
	} pixel_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  reg_index;
	logic [31:0] wr_data;

	apc_req_if req_ch();
	apc_res_if res_ch();

	anaglyph_pixel_compositor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (req_ch),
		.result    (res_ch),
		.wr_en     (wr_en),
		.reg_index (reg_index),
		.wr_data   (wr_data)
	);

	logic [23:0] palette_model [256];
	bit          slot_written [256];
	logic [7:0]  written_slots [$];
	logic        swap_model;
	logic [2:0]  format_model;
	logic [31:0] red_field;
	logic [31:0] green_field;
	logic [31:0] blue_field;

	pixel_t pending_pixels [$];

	bit send_idle;
	bit recv_idle;
	int res_gap;
	int hold_cycles;
	int failures;
	int stall_count;
	int n_writes;
	int n_pixels;
	int n_rejected;
	int n_checked;
	int n_settings;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] fit_channel(input logic [7:0] v, input logic [31:0] field);
		logic [31:0] m;
		int          sh;
		logic [63:0] q;
		if (field == 32'd0) begin
			return 32'd0;
		end
		m  = field;
		sh = 0;
		while (!m[0] && sh < 31) begin
			m = m >> 1;
			sh++;
		end
		q = (64'(v) * 64'(m) + 64'd127) / 64'd255;
		return 32'(q << sh);
	endfunction

	function automatic bit compose_pixel(input request_t it, output pixel_t px);
		logic [7:0]  red_src;
		logic [7:0]  cyan_src;
		logic [23:0] red_entry;
		logic [23:0] cyan_entry;
		logic [31:0] c;
		if (format_model > apc_pkg::FMT_32) begin
			return 1'b0;
		end
		red_src    = swap_model ? it.right : it.left;
		cyan_src   = swap_model ? it.left : it.right;
		px.overlay = (it.cur != it.right);
		if (px.overlay) begin
			red_src  = it.cur;
			cyan_src = it.cur;
		end
		red_entry  = palette_model[red_src];
		cyan_entry = palette_model[cyan_src];
		c = fit_channel(red_entry[23:16], red_field) |
		    fit_channel(cyan_entry[15:8], green_field) |
		    fit_channel(cyan_entry[7:0], blue_field);
		if (format_model == apc_pkg::FMT_15 || format_model == apc_pkg::FMT_16) begin
			px.nbytes = apc_pkg::BYTES_2;
			px.color  = c & 32'h0000_FFFF;
		end else if (format_model == apc_pkg::FMT_24) begin
			px.nbytes = apc_pkg::BYTES_3;
			px.color  = c & 32'h00FF_FFFF;
		end else begin
			px.nbytes = apc_pkg::BYTES_4;
			px.color  = c;
		end
		return 1'b1;
	endfunction

	function automatic request_t palette_write(input logic [7:0] slot, input logic [7:0] r,
	                                           input logic [7:0] g, input logic [7:0] b);
		request_t it;
		it.act   = apc_pkg::ACT_WRITE;
		it.slot  = slot;
		it.red   = r;
		it.green = g;
		it.blue  = b;
		it.left  = 8'($urandom);
		it.right = 8'($urandom);
		it.cur   = 8'($urandom);
		return it;
	endfunction

	function automatic request_t pixel_item(input logic [7:0] left, input logic [7:0] right,
	                                        input logic [7:0] cur);
		request_t it;
		it.act   = apc_pkg::ACT_PIXEL;
		it.slot  = 8'($urandom);
		it.red   = 8'($urandom);
		it.green = 8'($urandom);
		it.blue  = 8'($urandom);
		it.left  = left;
		it.right = right;
		it.cur   = cur;
		return it;
	endfunction

	function automatic logic [7:0] pick_written();
		return written_slots[$urandom_range(0, written_slots.size() - 1)];
	endfunction

	// Overlay pixels read only the current index, so the eye indices may be
	// anything; plain pixels read both eye entries, which must be written.
	function automatic request_t random_request();
		logic [7:0] cur;
		if ($urandom_range(0, 9) < 4) begin
			return palette_write(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end
		cur = pick_written();
		if ($urandom_range(0, 9) < 4) begin
			return pixel_item(8'($urandom), cur ^ 8'($urandom_range(1, 255)), cur);
		end
		return pixel_item(pick_written(), cur, cur);
	endfunction

	function automatic logic [31:0] draw_field();
		int w;
		int pos;
		case ($urandom_range(0, 5))
			0: begin
				return 32'd0;
			end
			1: begin
				return 32'hFFFF_FFFF;
			end
			2: begin
				return $urandom;
			end
			default: begin
				w   = $urandom_range(1, 32);
				pos = $urandom_range(0, 32 - w);
				return 32'(((64'd1 << w) - 64'd1) << pos);
			end
		endcase
	endfunction

	task automatic send_item(input request_t it);
		int     gap;
		pixel_t px;
		gap = send_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.action          <= it.act;
		req_ch.palette_slot    <= it.slot;
		req_ch.entry_red       <= it.red;
		req_ch.entry_green     <= it.green;
		req_ch.entry_blue      <= it.blue;
		req_ch.left_eye_index  <= it.left;
		req_ch.right_eye_index <= it.right;
		req_ch.current_index   <= it.cur;
		req_ch.valid           <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		if (it.act == apc_pkg::ACT_WRITE) begin
			n_writes++;
			palette_model[it.slot] = {it.red, it.green, it.blue};
			if (!slot_written[it.slot]) begin
				slot_written[it.slot] = 1'b1;
				written_slots.push_back(it.slot);
			end
		end else begin
			n_pixels++;
			if (compose_pixel(it, px)) begin
				pending_pixels.push_back(px);
			end else begin
				n_rejected++;
			end
		end
		@(negedge clk);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0) begin
			@(negedge clk);
		end
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
		wr_en     <= 1'b1;
		reg_index <= idx;
		wr_data   <= data;
		case (idx)
			apc_pkg::REG_SWAP:       swap_model   = data[0];
			apc_pkg::REG_FORMAT:     format_model = data[2:0];
			apc_pkg::REG_RED_MASK:   red_field    = data;
			apc_pkg::REG_GREEN_MASK: green_field  = data;
			apc_pkg::REG_BLUE_MASK:  blue_field   = data;
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	task automatic configure(input logic swap, input logic [2:0] fmt, input logic [31:0] rm,
	                         input logic [31:0] gm, input logic [31:0] bm);
		drain();
		write_register(apc_pkg::REG_SWAP, {31'($urandom), swap});
		write_register(apc_pkg::REG_FORMAT, {29'($urandom), fmt});
		write_register(apc_pkg::REG_RED_MASK, rm);
		write_register(apc_pkg::REG_GREEN_MASK, gm);
		write_register(apc_pkg::REG_BLUE_MASK, bm);
		write_register(3'($urandom_range(REG_UNUSED_MIN, REG_UNUSED_MAX)), $urandom);
		wr_en <= 1'b0;
		n_settings++;
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic test_extreme_colors();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		send_item(palette_write(8'h00, 8'h00, 8'h00, 8'h00));
		send_item(palette_write(8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_item(palette_write(8'h80, 8'hFF, 8'h00, 8'hFF));
		send_item(palette_write(8'h7F, 8'h00, 8'hFF, 8'h00));
		send_item(pixel_item(8'hFF, 8'h00, 8'h00));
		send_item(pixel_item(8'h00, 8'hFF, 8'hFF));
		send_item(pixel_item(8'h80, 8'h7F, 8'h7F));
		send_item(pixel_item(8'h00, 8'h00, 8'hFF));
		send_item(palette_write(8'h80, 8'h12, 8'h34, 8'h56));
		send_item(pixel_item(8'h7F, 8'h00, 8'h80));
	endtask

	task automatic test_formats_and_swap();
		for (int f = apc_pkg::FMT_15; f <= apc_pkg::FMT_32; f++) begin
			configure(f[0], 3'(f), RedMaskRst, GreenMaskRst, BlueMaskRst);
			send_item(pixel_item(8'hFF, 8'h80, 8'h80));
		end
	endtask

	task automatic test_unknown_format();
		configure(1'b0, FMT_UNKNOWN_MIN, RedMaskRst, GreenMaskRst, BlueMaskRst);
		send_item(pixel_item(8'hFF, 8'h00, 8'h00));
		send_item(palette_write(8'h33, 8'hC3, 8'h3C, 8'h5A));
		configure(1'b1, FMT_UNKNOWN_MAX, RedMaskRst, GreenMaskRst, BlueMaskRst);
		send_item(pixel_item(8'h33, 8'hFF, 8'hFF));
		configure(1'b0, apc_pkg::FMT_32, RedMaskRst, GreenMaskRst, BlueMaskRst);
		send_item(pixel_item(8'h00, 8'h00, 8'h33));
	endtask

	task automatic test_odd_masks();
		configure(1'b0, apc_pkg::FMT_32, 32'd0, 32'hF0F0_0F01, 32'hFFFF_FFFF);
		send_item(pixel_item(8'hFF, 8'h80, 8'h80));
		configure(1'b1, apc_pkg::FMT_30, 32'h8000_0000, 32'h0000_0001, 32'hA000_0000);
		send_item(pixel_item(8'h80, 8'hFF, 8'hFF));
	endtask

	task automatic test_random_traffic();
		logic [2:0] fmt;
		for (int ph = 0; ph < 10; ph++) begin
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 7) == 0) begin
				fmt = 3'($urandom_range(FMT_UNKNOWN_MIN, FMT_UNKNOWN_MAX));
			end else begin
				fmt = 3'($urandom_range(apc_pkg::FMT_15, apc_pkg::FMT_32));
			end
			if (ph == 0) begin
				configure(1'b0, apc_pkg::FMT_32, RedMaskRst, GreenMaskRst, BlueMaskRst);
			end else begin
				configure(1'($urandom), fmt, draw_field(), draw_field(), draw_field());
			end
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(0, 49) == 0) begin
					drain();
				end
				send_item(random_request());
			end
		end
	endtask

	task automatic test_result_stall();
		configure(1'($urandom), apc_pkg::FMT_24, draw_field(), draw_field(), draw_field());
		send_idle   = 1'b0;
		recv_idle   = 1'b0;
		hold_cycles = HoldOff;
		for (int n = 0; n < 40; n++) begin
			send_item(pixel_item(pick_written(), 8'h80, 8'h80));
		end
		drain();
	endtask

	initial begin : result_sink
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				res_ch.ready <= 1'b0;
			end else if (hold_cycles > 0) begin
				res_ch.ready <= 1'b0;
				hold_cycles--;
			end else if (res_gap > 0) begin
				res_ch.ready <= 1'b0;
				res_gap--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		pixel_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			res_gap = recv_idle ? $urandom_range(0, 6) : 0;
			if (pending_pixels.size() == 0) begin
				$error("unexpected result item: pixel_color %h", res_ch.pixel_color);
				failures++;
			end else begin
				want = pending_pixels.pop_front();
				n_checked++;
				if (res_ch.pixel_color !== want.color) begin
					$error("pixel_color expected %h got %h", want.color, res_ch.pixel_color);
					failures++;
				end
				if (res_ch.pixel_bytes !== want.nbytes) begin
					$error("pixel_bytes expected %0d got %0d", want.nbytes, res_ch.pixel_bytes);
					failures++;
				end
				if (res_ch.is_overlay !== want.overlay) begin
					$error("is_overlay expected %0d got %0d", want.overlay, res_ch.is_overlay);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			stall_count = 0;
		end else begin
			stall_count++;
			if (stall_count >= StallLimit) begin
				$display("Timed out after %0d cycles without an accepted item.", stall_count);
				$display("FAIL anaglyph_pixel_compositor");
				$finish;
			end
		end
	end

	initial begin : main
		arst_n                 = 1'b0;
		wr_en                  = 1'b0;
		reg_index              = apc_pkg::REG_SWAP;
		wr_data                = 32'd0;
		req_ch.valid           = 1'b0;
		req_ch.action          = apc_pkg::ACT_WRITE;
		req_ch.palette_slot    = 8'd0;
		req_ch.entry_red       = 8'd0;
		req_ch.entry_green     = 8'd0;
		req_ch.entry_blue      = 8'd0;
		req_ch.left_eye_index  = 8'd0;
		req_ch.right_eye_index = 8'd0;
		req_ch.current_index   = 8'd0;
		swap_model             = 1'b0;
		format_model           = apc_pkg::FMT_32;
		red_field              = RedMaskRst;
		green_field            = GreenMaskRst;
		blue_field             = BlueMaskRst;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_extreme_colors();
		test_formats_and_swap();
		test_unknown_format();
		test_odd_masks();
		test_random_traffic();
		test_result_stall();
		drain();

		if (pending_pixels.size() != 0) begin
			$error("%0d expected results never arrived", pending_pixels.size());
			failures++;
		end
		$display("Run covered %0d palette writes and %0d pixels (%0d rejected by format),",
		         n_writes, n_pixels, n_rejected);
		$display("with %0d results checked over %0d register settings.", n_checked, n_settings);
		if (failures == 0) begin
			$display("PASS anaglyph_pixel_compositor");
		end else begin
			$display("FAIL anaglyph_pixel_compositor");
		end
		$finish;
	end

endmodule
